/* sv/bspe_pkg.sv */
`timescale 1ns / 1ps
package bspe_pkg;
	localparam int MaxPoints = 64;
	localparam int MaxOrder = 8;
	localparam int FracBits = 16;
	localparam int KnotDepth = MaxPoints + MaxOrder;
	localparam int PtAw = $clog2(MaxPoints);
	localparam int KnAw = $clog2(KnotDepth);
	localparam int BwAw = $clog2(MaxOrder);

	localparam logic [1:0] ModePoint = 2'd0;
	localparam logic [1:0] ModeKnot = 2'd1;
	localparam logic [1:0] ModeEval = 2'd2;

	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StKnotDec = 3'd1;
	localparam logic [2:0] StRange = 3'd2;
	localparam logic [2:0] StClamp = 3'd3;
	localparam logic [2:0] StZero = 3'd4;

	localparam logic RegDegree = 1'b0;
	localparam logic RegPoints = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] param;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] num;
		logic signed [63:0] den;
	} div_req_t;

	function automatic logic signed [31:0] knot_default(input logic [KnAw-1:0] i);
		logic signed [63:0] v;
		v = 64'(i) <<< FracBits;
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		return v[31:0];
	endfunction
endpackage

/* sv/bspline_point_evaluator_top.sv */
`timescale 1ns / 1ps
// Writes: an accepted item passes S_WRD (knot read) and S_WRC (check and store write), and
// the result strobe is registered from S_WRC. Evaluation: a read and a write state per knot scan
// step and per copied point, then per blend term two serial divisions and a multiply pass per
// coordinate; a zero span skips both. Busy is high from acceptance until the result strobe.
// Reset and each configuration write refill all 72 knot store entries one entry a cycle, with
// busy high; after reset the point store is cleared in the same pass. The receiver cannot stall.
module bspline_point_evaluator_top
	import bspe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_item_t in_item,
	output logic done,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [6:0] cfg_data
);
	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_WRD, S_WRC, S_SCN_R, S_SCN_W, S_CP_R, S_CP_W,
		S_BK_R, S_BK_W, S_BP_R, S_BP_W, S_DA, S_DAW, S_DB, S_DBW,
		S_MUL, S_ADD, S_SAT, S_OUTR, S_OUT
	} st_t;
	st_t st_q;

	logic [2:0] deg_q;
	logic [6:0] pc_q;
	logic [4:0] ord;
	logic [6:0] np;
	logic [6:0] clr_q;
	logic pclr_q, kclr_q;
	in_item_t it_q;
	logic [6:0] off_q, lvl_q, i_q;
	logic [6:0] len_q;
	logic clamp_q, zs_q;
	logic signed [31:0] hi_q, lo_q, wa_q, wb_q;
	logic [1:0] c_q;
	logic signed [63:0] pa_q, pb_q;
	logic signed [31:0] ca_q, cb_q;
	logic [95:0] pv_q;

	logic pt_we, kn_we, bw_we;
	logic [PtAw-1:0] pt_wa, pt_ra;
	logic [KnAw-1:0] kn_wa, kn_ra;
	logic [BwAw-1:0] bw_wa, bw_ra;
	logic [95:0] pt_wd, pt_rd, bw_wd, bw_rd;
	logic [31:0] kn_wd, kn_rd;
	div_req_t dreq;
	logic ddone;
	logic signed [31:0] dq;
	logic [2:0] wr_status;

	bspe_ram #(.Width(96), .Depth(MaxPoints)) u_pt (.clk, .we(pt_we), .waddr(pt_wa),
		.wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
	bspe_ram #(.Width(32), .Depth(KnotDepth)) u_kn (.clk, .we(kn_we), .waddr(kn_wa),
		.wdata(kn_wd), .raddr(kn_ra), .rdata(kn_rd));
	bspe_ram #(.Width(96), .Depth(MaxOrder)) u_bw (.clk, .we(bw_we), .waddr(bw_wa),
		.wdata(bw_wd), .raddr(bw_ra), .rdata(bw_rd));
	bspe_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quot(dq));

	always_comb begin
		logic [4:0] o;
		o = (deg_q == 3'd0) ? 5'd2 : 5'(deg_q) + 5'd1;
		if (o > 5'(MaxOrder)) o = 5'(MaxOrder);
		ord = o;
		np = (pc_q < 7'(o)) ? 7'(o) : pc_q;
		if (np > 7'(MaxPoints)) np = 7'(MaxPoints);
	end

	assign busy = (st_q != S_IDLE);

	logic signed [63:0] sum;
	logic signed [63:0] fl;
	logic signed [31:0] sat_r;
	assign sum = pa_q + pb_q;
	assign fl = sum >>> FracBits;
	assign sat_r = (fl > 64'sd2147483647) ? 32'sh7fffffff :
		(fl < -64'sd2147483648) ? 32'sh80000000 : fl[31:0];

	always_comb begin
		wr_status = StOk;
		if (it_q.mode == ModePoint && 7'(it_q.index) >= np) begin
			wr_status = StRange;
		end else if (it_q.mode == ModeKnot) begin
			if (it_q.index >= np + 7'(ord)) wr_status = StRange;
			else if (it_q.index != 7'd0 && $signed(kn_rd) > it_q.param) wr_status = StKnotDec;
		end
	end

	always_comb begin
		pt_we = 1'b0; kn_we = 1'b0; bw_we = 1'b0;
		pt_wa = it_q.index[PtAw-1:0];
		pt_wd = {it_q.coord_x, it_q.coord_y, it_q.coord_z};
		kn_wa = it_q.index[KnAw-1:0];
		kn_wd = it_q.param;
		pt_ra = '0; kn_ra = '0;
		bw_ra = BwAw'(i_q + 7'd1);
		bw_wa = i_q[BwAw-1:0];
		bw_wd = pv_q;
		dreq = '0;
		case (st_q)
			S_CLR: begin
				if (pclr_q) begin
					pt_we = 1'b1;
					pt_wa = clr_q[PtAw-1:0];
					pt_wd = '0;
				end
				if (kclr_q) begin
					kn_we = 1'b1;
					kn_wa = clr_q[KnAw-1:0];
					kn_wd = knot_default(clr_q[KnAw-1:0]);
				end
			end
			S_WRC: begin
				if (it_q.mode == ModePoint && 7'(it_q.index) < np) pt_we = 1'b1;
				if (it_q.mode == ModeKnot && it_q.index < np + 7'(ord) &&
						!(it_q.index != 7'd0 && $signed(kn_rd) > it_q.param))
					kn_we = 1'b1;
			end
			S_WRD: kn_ra = KnAw'(it_q.index - 7'd1);
			S_SCN_R: kn_ra = KnAw'(7'(ord) + off_q);
			S_CP_R: pt_ra = PtAw'(off_q + i_q);
			S_CP_W: begin
				bw_we = 1'b1;
				bw_wd = pt_rd;
			end
			S_BK_R: kn_ra = KnAw'(off_q + len_q + i_q);
			S_BK_W: kn_ra = KnAw'(off_q + 7'd1 + i_q);
			S_BP_R: bw_ra = BwAw'(i_q);
			S_BP_W: bw_ra = BwAw'(i_q + 7'd1);
			S_DA: begin
				dreq.start = (hi_q != lo_q);
				dreq.num = (64'(hi_q) - 64'(it_q.param)) <<< FracBits;
				dreq.den = 64'(hi_q) - 64'(lo_q);
			end
			S_DB: begin
				dreq.start = 1'b1;
				dreq.num = (64'(it_q.param) - 64'(lo_q)) <<< FracBits;
				dreq.den = 64'(hi_q) - 64'(lo_q);
			end
			S_SAT: begin
				bw_we = (c_q == 2'd2);
				bw_wd = (hi_q == lo_q) ? '0 : {pv_q[95:32], sat_r};
			end
			S_OUTR: bw_ra = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			deg_q <= 3'd3;
			pc_q <= 7'd4;
			clr_q <= '0;
			pclr_q <= 1'b1;
			kclr_q <= 1'b1;
			done <= 1'b0;
		end else begin
			done <= !cfg_we && (st_q == S_WRC || st_q == S_OUT);
			if (cfg_we) begin
				if (cfg_index == RegDegree) deg_q <= cfg_data[2:0];
				else pc_q <= cfg_data;
				st_q <= S_CLR;
				clr_q <= '0;
				kclr_q <= 1'b1;
				pclr_q <= 1'b0;
			end else begin
				case (st_q)
					S_CLR: begin
						clr_q <= clr_q + 7'd1;
						if (clr_q == 7'(KnotDepth - 1)) begin
							st_q <= S_IDLE;
							pclr_q <= 1'b0;
							kclr_q <= 1'b0;
						end
					end
					S_IDLE: if (start) begin
						it_q <= in_item;
						off_q <= '0; i_q <= '0; lvl_q <= '0;
						len_q <= 7'(ord);
						clamp_q <= 1'b0; zs_q <= 1'b0;
						st_q <= (in_item.mode == ModeEval) ? S_SCN_R : S_WRD;
					end
					S_WRD: st_q <= S_WRC;
					S_WRC: begin
						out_item <= {wr_status, 96'd0};
						st_q <= S_IDLE;
					end
					S_SCN_R: st_q <= S_SCN_W;
					S_SCN_W: begin
						if ($signed(kn_rd) < it_q.param) begin
							if (off_q >= np - 7'(ord)) begin
								clamp_q <= 1'b1;
								st_q <= S_CP_R;
							end else begin
								off_q <= off_q + 7'd1;
								st_q <= S_SCN_R;
							end
						end else st_q <= S_CP_R;
					end
					S_CP_R: st_q <= S_CP_W;
					S_CP_W: begin
						if (i_q == 7'(ord) - 7'd1) begin
							i_q <= '0;
							st_q <= (ord == 5'd1) ? S_OUTR : S_BK_R;
						end else begin
							i_q <= i_q + 7'd1;
							st_q <= S_CP_R;
						end
					end
					S_BK_R: st_q <= S_BK_W;
					S_BK_W: begin
						hi_q <= kn_rd;
						st_q <= S_BP_R;
					end
					S_BP_R: begin
						lo_q <= kn_rd;
						st_q <= S_BP_W;
					end
					S_BP_W: begin
						pv_q <= bw_rd;
						st_q <= S_DA;
					end
					S_DA: begin
						if (hi_q == lo_q) begin
							zs_q <= 1'b1;
							pv_q <= '0;
							c_q <= 2'd2;
							st_q <= S_SAT;
						end else st_q <= S_DAW;
					end
					S_DAW: if (ddone) begin
						wa_q <= dq;
						st_q <= S_DB;
					end
					S_DB: st_q <= S_DBW;
					S_DBW: if (ddone) begin
						wb_q <= dq;
						c_q <= '0;
						st_q <= S_MUL;
					end
					S_MUL: begin
						case (c_q)
							2'd0: begin ca_q <= pv_q[95:64]; cb_q <= bw_rd[95:64]; end
							2'd1: begin ca_q <= pv_q[63:32]; cb_q <= bw_rd[63:32]; end
							default: begin ca_q <= pv_q[31:0]; cb_q <= bw_rd[31:0]; end
						endcase
						st_q <= S_ADD;
					end
					S_ADD: begin
						pa_q <= 64'(wa_q) * 64'(ca_q);
						pb_q <= 64'(wb_q) * 64'(cb_q);
						st_q <= S_SAT;
					end
					S_SAT: begin
						case (c_q)
							2'd0: pv_q[95:64] <= sat_r;
							2'd1: pv_q[63:32] <= sat_r;
							default: ;
						endcase
						if (c_q == 2'd2) begin
							c_q <= 2'd3;
							st_q <= S_OUTR;
						end else begin
							c_q <= c_q + 2'd1;
							st_q <= S_MUL;
						end
					end
					S_OUTR: begin
						if (c_q == 2'd3) begin
							c_q <= '0;
							if (i_q + 7'd2 < len_q) begin
								i_q <= i_q + 7'd1;
								st_q <= S_BK_R;
							end else if (lvl_q + 7'd2 < 7'(ord)) begin
								i_q <= '0;
								lvl_q <= lvl_q + 7'd1;
								len_q <= len_q - 7'd1;
								off_q <= off_q + 7'd1;
								st_q <= S_BK_R;
							end else st_q <= S_OUT;
						end else st_q <= S_OUT;
					end
					S_OUT: begin
						out_item.status <= zs_q ? StZero : (clamp_q ? StClamp : StOk);
						out_item.point_x <= bw_rd[95:64];
						out_item.point_y <= bw_rd[63:32];
						out_item.point_z <= bw_rd[31:0];
						st_q <= S_IDLE;
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("double result");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept without busy");
`endif
endmodule

/* sv/bspe_ram.sv */
`timescale 1ns / 1ps
module bspe_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* sv/bspe_div.sv */
`timescale 1ns / 1ps
module bspe_div
	import bspe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic done,
	output logic signed [31:0] quot
);
	logic [63:0] rem_q, dvs_q, quo_q;
	logic neg_q, busy_q;
	logic [5:0] cnt_q;
	logic [64:0] trial;
	logic [63:0] remsh;
	logic signed [64:0] sq;
	logic [63:0] an, ad;

	assign an = req.num[63] ? 64'(-req.num) : 64'(req.num);
	assign ad = req.den[63] ? 64'(-req.den) : 64'(req.den);
	assign remsh = {rem_q[62:0], quo_q[63]};
	assign trial = {1'b0, remsh} - {1'b0, dvs_q};
	assign sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= busy_q && !req.start && (cnt_q == 6'd63);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= an;
				dvs_q <= ad;
				neg_q <= req.num[63] ^ req.den[63];
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= remsh;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (sq > 65'sd2147483647) quot = 32'sh7fffffff;
		else if (sq < -65'sd2147483647) quot = -32'sh7fffffff;
		else quot = sq[31:0];
	end
endmodule
